// ----- hw/rtl/scfr_pkg.sv -----
// Package for the serial command frame receiver: item and result structures,
// status codes, register decode and the end-around-carry checksum helper.
// No dependencies.
package scfr_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CountW = 3;
	localparam int unsigned StoreDepth = 4;
	localparam int unsigned DataW = 32;
	localparam int unsigned AddrW = 3;

	localparam logic [CountW-1:0] FRAME_LEN = 3'd5;
	localparam logic [CountW-1:0] SUM_LEN = 3'd4;

	localparam logic [ByteW-1:0] HS_DIV_RESET = 8'd7;
	localparam logic [ByteW-1:0] NS_DIV_RESET = 8'd40;

	// Input event codes; the fourth code is unused and ignored.
	localparam logic [1:0] KIND_ASSERT = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	// Register select taken from paddr[2]; the low address bits are ignored.
	localparam logic REG_HIGH_SPEED_DIV = 1'b0;
	localparam logic REG_NORMAL_SPEED_DIV = 1'b1;

	typedef enum logic [1:0] {
		STATUS_VALID = 2'd0,
		STATUS_BAD_SUM = 2'd1,
		STATUS_RX_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ByteW-1:0] data_byte;
		logic             receive_error;
	} in_item_t;

	typedef struct packed {
		status_t          frame_status;
		logic [ByteW-1:0] unit_id;
		logic [ByteW-1:0] command_code;
		logic [ByteW-1:0] aux_low;
		logic [ByteW-1:0] aux_high;
		logic [ByteW-1:0] speed_divisor;
		logic             high_speed;
	} result_t;

	typedef struct packed {
		logic [ByteW-1:0] high_speed_div;
		logic [ByteW-1:0] normal_speed_div;
	} cfg_t;

	// Ones' complement style addition: a carry out of bit 7 wraps back in.
	function automatic logic [ByteW-1:0] add_eac(input logic [ByteW-1:0] sum,
			input logic [ByteW-1:0] b);
		logic [ByteW:0] s;
		s = {1'b0, sum} + {1'b0, b};
		return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
	endfunction

endpackage

// ----- hw/rtl/scfr_cfg_regs.sv -----
// APB-style register file holding the two serial clock divisors.
// Depends on scfr_pkg.
module scfr_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scfr_pkg::AddrW-1:0]  paddr,
	input  logic [scfr_pkg::DataW-1:0]  pwdata,
	output logic [scfr_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output scfr_pkg::cfg_t              cfg
);
	import scfr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_speed_div <= HS_DIV_RESET;
			cfg_q.normal_speed_div <= NS_DIV_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_HIGH_SPEED_DIV: cfg_q.high_speed_div <= pwdata[ByteW-1:0];
				REG_NORMAL_SPEED_DIV: cfg_q.normal_speed_div <= pwdata[ByteW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HIGH_SPEED_DIV: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.high_speed_div};
			REG_NORMAL_SPEED_DIV: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.normal_speed_div};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/scfr_in_stage.sv -----
// Input register of the receiver: captures one request per cycle and holds
// it while the result side is blocked. Depends on scfr_pkg.
module scfr_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  scfr_pkg::in_item_t  in_item,
	input  logic                advance,
	output logic                valid_s1,
	output scfr_pkg::in_item_t  item_s1
);
	import scfr_pkg::*;

	logic load;

	// The register refills whenever its current content moves on or it is empty.
	assign load = advance | ~valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- hw/rtl/scfr_frame_core.sv -----
// Frame state and evaluation: byte collection, running checksum, error
// tracking and the speed mode toggle. Depends on scfr_pkg.
module scfr_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  scfr_pkg::in_item_t  item_s1,
	input  logic                advance,
	input  scfr_pkg::cfg_t      cfg,
	output logic                res_valid,
	output scfr_pkg::result_t   res
);
	import scfr_pkg::*;

	logic [CountW-1:0] byte_count_q;
	logic [ByteW-1:0]  frame_store_q [StoreDepth];
	logic [ByteW-1:0]  running_sum_q;
	logic [ByteW-1:0]  check_value_q;
	logic              error_seen_q;
	logic              high_speed_q;
	logic              line_active_q;

	logic    step;
	logic    take_byte;
	logic    is_release;
	logic    toggle;
	status_t status;

	assign step = valid_s1 & advance;
	assign take_byte = (item_s1.kind == KIND_BYTE) & line_active_q & ~error_seen_q
		& (byte_count_q < FRAME_LEN);
	assign is_release = (item_s1.kind == KIND_RELEASE) & line_active_q;

	always_comb begin
		if (error_seen_q || (byte_count_q < FRAME_LEN)) begin
			status = STATUS_RX_ERROR;
		end else if (check_value_q != running_sum_q) begin
			status = STATUS_BAD_SUM;
		end else begin
			status = STATUS_VALID;
		end
	end

	assign toggle = (status != STATUS_VALID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			running_sum_q <= '0;
			check_value_q <= '0;
			error_seen_q <= 1'b0;
			high_speed_q <= 1'b0;
			line_active_q <= 1'b0;
		end else if (step) begin
			case (item_s1.kind)
				KIND_ASSERT: begin
					byte_count_q <= '0;
					running_sum_q <= '0;
					check_value_q <= '0;
					error_seen_q <= 1'b0;
					line_active_q <= 1'b1;
				end
				KIND_BYTE: begin
					if (take_byte) begin
						if (item_s1.receive_error) begin
							error_seen_q <= 1'b1;
						end else begin
							if (byte_count_q < SUM_LEN) begin
								running_sum_q <= add_eac(running_sum_q, item_s1.data_byte);
							end else begin
								check_value_q <= item_s1.data_byte;
							end
							byte_count_q <= byte_count_q + 3'd1;
						end
					end
				end
				KIND_RELEASE: begin
					if (is_release) begin
						line_active_q <= 1'b0;
						if (toggle) begin
							high_speed_q <= ~high_speed_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && take_byte && !item_s1.receive_error && (byte_count_q < SUM_LEN)) begin
			frame_store_q[byte_count_q[1:0]] <= item_s1.data_byte;
		end
	end

	logic new_hs;

	assign new_hs = high_speed_q ^ toggle;
	assign res_valid = valid_s1 & is_release;

	always_comb begin
		res.frame_status = status;
		if (status == STATUS_RX_ERROR) begin
			res.unit_id = '0;
			res.command_code = '0;
			res.aux_low = '0;
			res.aux_high = '0;
		end else begin
			res.unit_id = frame_store_q[0];
			res.command_code = frame_store_q[1];
			res.aux_low = frame_store_q[2];
			res.aux_high = frame_store_q[3];
		end
		res.speed_divisor = new_hs ? cfg.high_speed_div : cfg.normal_speed_div;
		res.high_speed = new_hs;
	end

endmodule

// ----- hw/rtl/scfr_out_stage.sv -----
// Result register of the receiver: holds one result until the downstream
// side takes it. Depends on scfr_pkg.
module scfr_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  scfr_pkg::result_t  res,
	input  logic               out_stall,
	output logic               advance,
	output logic               out_valid,
	output scfr_pkg::result_t  out_res
);
	import scfr_pkg::*;

	logic    out_valid_q;
	result_t out_res_q;

	assign advance = ~(out_valid_q & out_stall);
	assign out_valid = out_valid_q;
	assign out_res = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

endmodule

// ----- hw/rtl/sio_command_frame_receiver.sv -----
// Top level of the serial command frame receiver.
// Depends on scfr_pkg, scfr_cfg_regs, scfr_in_stage, scfr_frame_core and
// scfr_out_stage.
//
// Each input request is a line event or a received byte (kind, data_byte,
// receive_error). An assert opens a frame; up to five bytes are then taken
// (unit, command, aux1, aux2, check). A release of an open frame gives one
// result: status, the four frame bytes (zero on a receive error or short
// frame) and the serial divisor in use after the speed toggle that follows
// any failure. Other requests give no result.
// A request is captured in the input register and evaluated from there into the
// result register, which offers the result of a release request to the
// downstream side. One request is taken every cycle unless in_stall is raised.
// When the receiver stalls with a result waiting, the input register holds
// its request and in_stall rises once that register is full.
// Reset returns both divisors to 7 and 40, closes any frame and selects normal
// speed. Divisors are written over APB at byte addresses 0 (high speed) and 4
// (normal speed), by the user only while idle; the block does not enforce it.
module sio_command_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [7:0]                  data_byte,
	input  logic                        receive_error,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  frame_status,
	output logic [7:0]                  unit_id,
	output logic [7:0]                  command_code,
	output logic [7:0]                  aux_low,
	output logic [7:0]                  aux_high,
	output logic [7:0]                  speed_divisor,
	output logic                        high_speed,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scfr_pkg::AddrW-1:0]  paddr,
	input  logic [scfr_pkg::DataW-1:0]  pwdata,
	output logic [scfr_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import scfr_pkg::*;

	cfg_t     cfg;
	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	assign in_item.kind = kind;
	assign in_item.data_byte = data_byte;
	assign in_item.receive_error = receive_error;

	assign in_stall = valid_s1 & ~advance;

	scfr_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	scfr_frame_core u_frame_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	scfr_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign frame_status = out_res.frame_status;
	assign unit_id = out_res.unit_id;
	assign command_code = out_res.command_code;
	assign aux_low = out_res.aux_low;
	assign aux_high = out_res.aux_high;
	assign speed_divisor = out_res.speed_divisor;
	assign high_speed = out_res.high_speed;

endmodule

// ----- tb/sio_command_frame_receiver_test.sv -----
// Testbench for sio_command_frame_receiver: frame requests with random idling and
// stalls, an in-file predictor of status, frame bytes and speed toggling, APB checks.
// Depends on scfr_pkg and the receiver RTL only.
module sio_command_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	import scfr_pkg::*;

	localparam int PIPE_DEPTH = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_REQUESTS = 600;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum int {
		SHAPE_GOOD,
		SHAPE_BAD_SUM,
		SHAPE_RX_ERROR,
		SHAPE_SHORT,
		SHAPE_EXTRA,
		SHAPE_RESTART
	} frame_shape_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = 2'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        receive_error = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  frame_status;
	logic [7:0]  unit_id;
	logic [7:0]  command_code;
	logic [7:0]  aux_low;
	logic [7:0]  aux_high;
	logic [7:0]  speed_divisor;
	logic        high_speed;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic        pready;

	sio_command_frame_receiver dut (.*);

	// Predictor state: the open frame, its bytes and checksum, and the speed selection.
	logic        frame_open = 1'b0;
	logic [2:0]  bytes_taken = 3'd0;
	logic [7:0]  frame_bytes [4] = '{default: 8'h00};
	logic [7:0]  sum_acc = 8'h00;
	logic [7:0]  check_byte = 8'h00;
	logic        rx_fault = 1'b0;
	logic        fast_mode = 1'b0;
	logic [7:0]  fast_div = HS_DIV_RESET;
	logic [7:0]  slow_div = NS_DIV_RESET;

	result_t pending_results [$];
	int mismatches = 0;
	int requests_sent = 0;
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] ones_add(input logic [7:0] acc, input logic [7:0] b);
		logic [8:0] total;
		total = {1'b0, acc} + {1'b0, b};
		if (total > 9'd255)
			total = total - 9'd255;
		return total[7:0];
	endfunction

	// Advances the predictor by one request; returns 1 when a frame result follows.
	function automatic bit predict_frame(input in_item_t req, output result_t res);
		status_t st;
		res = '0;
		case (req.kind)
			KIND_ASSERT: begin
				frame_open = 1'b1;
				bytes_taken = 3'd0;
				sum_acc = 8'h00;
				check_byte = 8'h00;
				rx_fault = 1'b0;
				return 1'b0;
			end
			KIND_BYTE: begin
				if (!frame_open || rx_fault || bytes_taken >= FRAME_LEN)
					return 1'b0;
				if (req.receive_error) begin
					rx_fault = 1'b1;
					return 1'b0;
				end
				if (bytes_taken < SUM_LEN) begin
					frame_bytes[bytes_taken[1:0]] = req.data_byte;
					sum_acc = ones_add(sum_acc, req.data_byte);
				end else begin
					check_byte = req.data_byte;
				end
				bytes_taken = bytes_taken + 3'd1;
				return 1'b0;
			end
			KIND_RELEASE: begin
				if (!frame_open)
					return 1'b0;
				frame_open = 1'b0;
				if (rx_fault || bytes_taken < FRAME_LEN)
					st = STATUS_RX_ERROR;
				else if (check_byte != sum_acc)
					st = STATUS_BAD_SUM;
				else
					st = STATUS_VALID;
				if (st != STATUS_VALID)
					fast_mode = !fast_mode;
				res.frame_status = st;
				if (st != STATUS_RX_ERROR) begin
					res.unit_id = frame_bytes[0];
					res.command_code = frame_bytes[1];
					res.aux_low = frame_bytes[2];
					res.aux_high = frame_bytes[3];
				end
				res.speed_divisor = fast_mode ? fast_div : slow_div;
				res.high_speed = fast_mode;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic frame_shape_t pick_shape();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40) return SHAPE_GOOD;
		if (roll < 55) return SHAPE_BAD_SUM;
		if (roll < 70) return SHAPE_RX_ERROR;
		if (roll < 80) return SHAPE_SHORT;
		if (roll < 90) return SHAPE_EXTRA;
		return SHAPE_RESTART;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_request(input logic [1:0] kd, input logic [7:0] byte_val,
			input logic err_flag);
		in_item_t req;
		result_t res;
		req.kind = kd;
		req.data_byte = byte_val;
		req.receive_error = err_flag;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= kd;
		data_byte <= byte_val;
		receive_error <= err_flag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (predict_frame(req, res))
			pending_results.push_back(res);
		requests_sent++;
	endtask

	task automatic send_frame(input frame_shape_t shape);
		logic [7:0] body [5];
		logic [7:0] sum;
		int n_bytes;
		int fault_at;
		int i;
		sum = 8'h00;
		for (i = 0; i < 4; i++) begin
			body[i] = pick_byte();
			sum = ones_add(sum, body[i]);
		end
		body[4] = sum;
		if (shape == SHAPE_BAD_SUM)
			body[4] = sum ^ 8'($urandom_range(1, 255));
		n_bytes = 5;
		fault_at = -1;
		case (shape)
			SHAPE_SHORT: n_bytes = $urandom_range(0, 4);
			SHAPE_EXTRA: n_bytes = 5 + $urandom_range(1, 3);
			SHAPE_RX_ERROR: fault_at = $urandom_range(0, 4);
			SHAPE_RESTART: begin
				// A frame cut short by a fresh assert.
				send_request(KIND_ASSERT, pick_byte(), 1'($urandom_range(1)));
				repeat ($urandom_range(1, 4))
					send_request(KIND_BYTE, pick_byte(), 1'b0);
			end
			default: ;
		endcase
		send_request(KIND_ASSERT, pick_byte(), 1'($urandom_range(1)));
		for (i = 0; i < n_bytes; i++)
			send_request(KIND_BYTE, (i < 5) ? body[i] : pick_byte(), i == fault_at);
		send_request(KIND_RELEASE, pick_byte(), 1'($urandom_range(1)));
	endtask

	// Stops offering requests and waits until every expected frame result has arrived.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH)
			@(posedge clk);
	endtask

	task automatic read_divisor(input logic sel);
		logic [7:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = (sel == REG_HIGH_SPEED_DIV) ? fast_div : slow_div;
		if (prdata[7:0] !== want) begin
			$display("%0t: divisor read at %0d expected %0h, got %0h", $time, sel, want,
				prdata[7:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_divisor(input logic sel, input logic [7:0] value);
		logic [DataW-1:0] word;
		word = $urandom;
		word[7:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_HIGH_SPEED_DIV)
			fast_div = value;
		else
			slow_div = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		read_divisor(sel);
	endtask

	task automatic test_reset_values();
		read_divisor(REG_HIGH_SPEED_DIV);
		read_divisor(REG_NORMAL_SPEED_DIV);
	endtask

	task automatic test_directed_cases();
		int i;
		// Full frame of 0xff bytes with one extra byte that must be ignored.
		send_request(KIND_ASSERT, 8'h00, 1'b0);
		for (i = 0; i < 6; i++)
			send_request(KIND_BYTE, 8'hff, 1'b0);
		send_request(KIND_RELEASE, 8'hff, 1'b1);
		// Requests with no open frame and the unused kind code.
		send_request(KIND_BYTE, 8'h5a, 1'b0);
		send_request(KIND_RELEASE, 8'h00, 1'b0);
		send_request(KIND_UNUSED, 8'hff, 1'b1);
		// Receive error on the first byte; the following byte is ignored.
		send_request(KIND_ASSERT, 8'hff, 1'b1);
		send_request(KIND_BYTE, 8'h12, 1'b1);
		send_request(KIND_BYTE, 8'h34, 1'b0);
		send_request(KIND_RELEASE, 8'h00, 1'b0);
		// An assert in an open frame restarts it, leaving an empty frame.
		send_request(KIND_ASSERT, 8'h00, 1'b0);
		send_request(KIND_BYTE, 8'h77, 1'b0);
		send_request(KIND_ASSERT, 8'h00, 1'b0);
		send_request(KIND_RELEASE, 8'h00, 1'b0);
		// Checksum mismatch with a carry wrapping round.
		send_request(KIND_ASSERT, 8'h00, 1'b0);
		for (i = 0; i < 4; i++)
			send_request(KIND_BYTE, 8'h80, 1'b0);
		send_request(KIND_BYTE, 8'h00, 1'b0);
		send_request(KIND_RELEASE, 8'h00, 1'b0);
	endtask

	task automatic test_register_settings();
		int p;
		for (p = 0; p < 3; p++) begin
			wait_drained();
			case (p)
				0: begin
					write_divisor(REG_HIGH_SPEED_DIV, 8'h00);
					write_divisor(REG_NORMAL_SPEED_DIV, 8'hff);
				end
				1: begin
					write_divisor(REG_HIGH_SPEED_DIV, 8'hff);
					write_divisor(REG_NORMAL_SPEED_DIV, 8'h00);
				end
				default: begin
					write_divisor(REG_HIGH_SPEED_DIV, 8'($urandom));
					write_divisor(REG_NORMAL_SPEED_DIV, 8'($urandom));
				end
			endcase
			repeat (10)
				send_frame(pick_shape());
		end
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering frames, so the block
	// fills and stalls its input; then the sender waits for every result.
	task automatic test_output_hold_off();
		hold_request = 1'b1;
		repeat (20)
			send_frame(pick_shape());
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int first;
		int done;
		int next_cfg;
		first = requests_sent;
		next_cfg = 250;
		done = 0;
		while (done < RANDOM_REQUESTS) begin
			if (done >= next_cfg) begin
				calm = 1'b0;
				wait_drained();
				write_divisor(REG_HIGH_SPEED_DIV, 8'($urandom));
				write_divisor(REG_NORMAL_SPEED_DIV, 8'($urandom));
				next_cfg += 250;
			end
			calm = (done >= 350 && done < 550);
			if ($urandom_range(99) < 80)
				send_frame(pick_shape());
			else
				send_request(2'($urandom_range(3)), pick_byte(), 1'($urandom_range(1)));
			done = requests_sent - first;
		end
		calm = 1'b0;
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 27);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d", $time,
					frame_status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("frame_status", 8'(want.frame_status), 8'(frame_status));
				check_field("unit_id", want.unit_id, unit_id);
				check_field("command_code", want.command_code, command_code);
				check_field("aux_low", want.aux_low, aux_low);
				check_field("aux_high", want.aux_high, aux_high);
				check_field("speed_divisor", want.speed_divisor, speed_divisor);
				check_field("high_speed", 8'(want.high_speed), 8'(high_speed));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("sio_command_frame_receiver_test: errors");
		$finish;
	end

	initial begin
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_cases();
		test_register_settings();
		test_output_hold_off();
		test_random_traffic();
		if (mismatches == 0)
			$display("sio_command_frame_receiver_test: clean");
		else
			$display("sio_command_frame_receiver_test: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_cfg_regs.sv
hw/rtl/scfr_in_stage.sv
hw/rtl/scfr_frame_core.sv
hw/rtl/scfr_out_stage.sv
hw/rtl/sio_command_frame_receiver.sv
tb/sio_command_frame_receiver_test.sv
